// ===== rtl/rlsd_pkg.sv =====
// Package for the run-length stream decoder.
// Holds item structs, the front-to-back command struct, phase and status codes.
// No dependencies.
package rlsd_pkg;

    // Input item: one compressed byte or an end-of-input marker
    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [7:0]  out_value;
        logic [15:0] repeat_count;
        logic [1:0]  status;
        logic [31:0] produced_total;
    } t_out_item;

    // Result status codes
    localparam logic [1:0] ST_DATA      = 2'd0;
    localparam logic [1:0] ST_MATCH     = 2'd1;
    localparam logic [1:0] ST_MISMATCH  = 2'd2;
    localparam logic [1:0] ST_PREMATURE = 2'd3;

    // Parser phase
    typedef enum logic [2:0] {
        PH_HDR_LO,
        PH_HDR_HI,
        PH_LITERAL,
        PH_RUN,
        PH_TRAILER,
        PH_STOPPED
    } t_phase;

    // Command kinds passed from front to back
    typedef enum logic [1:0] {
        CMD_DATA,
        CMD_CHECK,
        CMD_PREMATURE
    } t_cmd_kind;

    // Command from the parser to the executor
    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  value;
        logic [15:0] count;
        logic [31:0] expected;
    } t_cmd;

endpackage

// ===== rtl/rlsd_front.sv =====
// Front end of the run-length stream decoder: parses headers, literals, runs
// and the size trailer and issues one command per result. Uses rlsd_pkg.
module rlsd_front
    import rlsd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_in_item i_item,
    output logic     o_push,
    output t_cmd     o_cmd
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_hdr_low, n_hdr_low;
    logic [15:0] r_header, n_header;
    logic [14:0] r_lit_left, n_lit_left;
    logic [23:0] r_trailer, n_trailer;
    logic [1:0]  r_tr_idx, n_tr_idx;

    logic [15:0] hdr_word;
    logic [14:0] lit_dec;

    assign hdr_word = {i_item.in_byte, r_hdr_low};
    assign lit_dec  = r_lit_left - 15'd1;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_fire && r_phase != PH_STOPPED) begin
            if (i_item.stream_end) begin
                n_phase = PH_STOPPED;
            end else begin
                case (r_phase)
                    PH_HDR_LO: n_phase = PH_HDR_HI;
                    PH_HDR_HI: begin
                        if (hdr_word == 16'd0) begin
                            n_phase = PH_TRAILER;
                        end else if (hdr_word[15]) begin
                            n_phase = PH_RUN;
                        end else begin
                            n_phase = PH_LITERAL;
                        end
                    end
                    PH_LITERAL: begin
                        if (lit_dec == 15'd0) n_phase = PH_HDR_LO;
                    end
                    PH_RUN:     n_phase = PH_HDR_LO;
                    PH_TRAILER: begin
                        if (r_tr_idx == 2'd3) n_phase = PH_STOPPED;
                    end
                    default:    n_phase = PH_STOPPED;
                endcase
            end
        end
    end

    // Commands and datapath updates
    always_comb begin
        o_push     = 1'b0;
        o_cmd      = '{kind: CMD_DATA, value: i_item.in_byte, count: 16'd1,
                       expected: {i_item.in_byte, r_trailer}};
        n_hdr_low  = r_hdr_low;
        n_header   = r_header;
        n_lit_left = r_lit_left;
        n_trailer  = r_trailer;
        n_tr_idx   = r_tr_idx;
        if (i_fire && r_phase != PH_STOPPED) begin
            if (i_item.stream_end) begin
                o_push     = 1'b1;
                o_cmd.kind = CMD_PREMATURE;
            end else begin
                case (r_phase)
                    PH_HDR_LO: n_hdr_low = i_item.in_byte;
                    PH_HDR_HI: begin
                        n_header   = hdr_word;
                        n_lit_left = hdr_word[14:0];
                        n_trailer  = '0;
                        n_tr_idx   = '0;
                    end
                    PH_LITERAL: begin
                        o_push     = 1'b1;
                        n_lit_left = lit_dec;
                    end
                    PH_RUN: begin
                        // run length is the negated header, 1 to 32768
                        o_push      = 1'b1;
                        o_cmd.count = (~r_header) + 16'd1;
                    end
                    PH_TRAILER: begin
                        if (r_tr_idx == 2'd3) begin
                            o_push     = 1'b1;
                            o_cmd.kind = CMD_CHECK;
                        end else begin
                            case (r_tr_idx)
                                2'd0:    n_trailer[7:0]   = i_item.in_byte;
                                2'd1:    n_trailer[15:8]  = i_item.in_byte;
                                default: n_trailer[23:16] = i_item.in_byte;
                            endcase
                            n_tr_idx = r_tr_idx + 2'd1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR_LO;
            r_hdr_low  <= '0;
            r_header   <= '0;
            r_lit_left <= '0;
            r_trailer  <= '0;
            r_tr_idx   <= '0;
        end else begin
            r_phase    <= n_phase;
            r_hdr_low  <= n_hdr_low;
            r_header   <= n_header;
            r_lit_left <= n_lit_left;
            r_trailer  <= n_trailer;
            r_tr_idx   <= n_tr_idx;
        end
    end

endmodule

// ===== rtl/rlsd_queue.sv =====
// Short command queue between the parser and the executor.
// Uses rlsd_pkg for the command type.
module rlsd_queue
    import rlsd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_cmd;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PW'(1);
            if (do_pop)  r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PW'(1);
            if (do_push && !do_pop)      r_count <= r_count + CW'(1);
            else if (do_pop && !do_push) r_count <= r_count - CW'(1);
        end
    end

endmodule

// ===== rtl/rlsd_back.sv =====
// Back end of the run-length stream decoder: keeps the decoded byte count,
// checks the trailer size and holds the result register. Uses rlsd_pkg.
module rlsd_back
    import rlsd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_avail,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    logic [31:0] r_total, n_total;
    logic        r_valid;
    t_out_item   r_out, n_out;

    // Take a command whenever the result register is free or draining
    assign o_pop   = i_cmd_avail && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_data  = r_out;

    // Execute the command at the head of the queue
    always_comb begin
        n_total = r_total + {16'd0, i_cmd.count};
        n_out   = '{out_value: 8'd0, repeat_count: 16'd0, status: ST_PREMATURE,
                    produced_total: r_total};
        case (i_cmd.kind)
            CMD_DATA: begin
                n_out.out_value      = i_cmd.value;
                n_out.repeat_count   = i_cmd.count;
                n_out.status         = ST_DATA;
                n_out.produced_total = n_total;
            end
            CMD_CHECK: begin
                n_out.status = (i_cmd.expected == r_total) ? ST_MATCH : ST_MISMATCH;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_total <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                if (i_cmd.kind == CMD_DATA) r_total <= n_total;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) r_out <= n_out;
    end

endmodule

// ===== rtl/run_length_stream_decoder_core.sv =====
// Run-length stream decoder, top level. Takes one compressed byte per cycle
// and returns literal bytes and repeat runs as (byte, count) results, then a
// final status: sizes match, size mismatch or premature end. The block accepts
// one item every cycle while the command queue has room; a result is
// registered in the command queue, then the result register. Output stalls are
// absorbed by the QUEUE_DEPTH-entry command queue between the parser and the
// executor before the input stalls. After a final status every item is
// accepted and dropped until reset. Depends on rlsd_pkg and the rlsd_* modules.
module run_length_stream_decoder_core
    import rlsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    logic q_full, q_empty, push, pop, in_fire;
    t_cmd front_cmd, head_cmd;

    assign o_stall = q_full;
    assign in_fire = i_valid && !q_full;

    // Parser
    rlsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (in_fire),
        .i_item  (i_data),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    // Command queue
    rlsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    // Executor and result register
    rlsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_avail (!q_empty),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

endmodule
